// ===== hw/rtl/aips_pkg.sv =====
// Shared types and constants of the active/inactive poll scheduler.
// No dependencies; imported by the controller, datapath, top level and checker.
`default_nettype none

package aips_pkg;

    localparam int DEV_W    = 6;   // device number field width
    localparam int PERIOD_W = 8;   // inactive poll period and poll counter width

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd16;

    localparam logic MODE_POLL   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take_report;  // apply a presence report word
        logic take_poll;    // start a poll: advance the poll counter
        logic scan;         // a search is evaluated this cycle
        logic second;       // search the fall-through set
        logic commit;       // let the search update pointer and result
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;          // current search finds a device
        logic out_free;     // result register can take a word this cycle
    } t_ctl_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/aips_datapath.sv =====
// Datapath of the poll scheduler: presence map, pointers, poll counter,
// rotating search and result register. Depends on aips_pkg.
`default_nettype none

module aips_datapath import aips_pkg::*; #(
    parameter int NUM_DEVICES = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [PERIOD_W-1:0] i_cfg_wr_data,
    input  wire logic [DEV_W-1:0]    i_device,
    input  wire logic                i_responded,
    input  wire logic                i_out_ready,
    input  wire t_ctl_cmd            i_cmd,
    output t_ctl_sts                 o_sts,
    output logic                     o_out_valid,
    output logic [DEV_W-1:0]         o_next_device
);

    localparam int IDX_W   = $clog2(NUM_DEVICES);
    localparam int RST_PTR = 31 % NUM_DEVICES;

    logic [NUM_DEVICES-1:0] r_map, n_map;
    logic [IDX_W-1:0]       r_act_ptr, n_act_ptr, r_ina_ptr, n_ina_ptr;
    logic                   r_act_vld, n_act_vld, r_ina_vld, n_ina_vld;
    logic [PERIOD_W-1:0]    r_period, r_cnt, n_cnt;
    logic                   r_skip, n_skip;
    logic                   r_out_valid, n_out_valid;
    logic [DEV_W-1:0]       r_next_device, n_next_device;

    logic                   want_act;
    logic [IDX_W-1:0]       cur_ptr;
    logic                   cur_vld;
    logic [IDX_W:0]         ptr_inc;
    logic [IDX_W-1:0]       start;
    logic [NUM_DEVICES-1:0] target, upper;
    logic [IDX_W:0]         hit_up, hit_all;
    logic [IDX_W-1:0]       found;
    logic                   hit;
    logic [DEV_W:0]         dev_ext;
    logic [DEV_W-1:0]       dev_m1;
    logic                   dev_ok;

    // lowest set bit: {found, index}
    function automatic logic [IDX_W:0] first_one(input logic [NUM_DEVICES-1:0] v);
        logic [IDX_W:0] res;
        res = '0;
        for (int i = NUM_DEVICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, IDX_W'(i)};
            end
        end
        return res;
    endfunction

    // first search is active unless this pass polls the inactive set
    assign want_act = ~(r_skip ^ i_cmd.second);
    assign cur_ptr  = want_act ? r_act_ptr : r_ina_ptr;
    assign cur_vld  = want_act ? r_act_vld : r_ina_vld;
    assign ptr_inc  = {1'b0, cur_ptr} + (IDX_W+1)'(1);
    assign start    = (cur_vld && (ptr_inc < (IDX_W+1)'(NUM_DEVICES))) ?
                      ptr_inc[IDX_W-1:0] : '0;
    assign target   = want_act ? r_map : ~r_map;
    assign upper    = target & ({NUM_DEVICES{1'b1}} << start);
    assign hit_up   = first_one(upper);
    assign hit_all  = first_one(target);
    assign hit      = hit_all[IDX_W];
    assign found    = hit_up[IDX_W] ? hit_up[IDX_W-1:0] : hit_all[IDX_W-1:0];

    assign dev_ext  = {1'b0, i_device};
    assign dev_m1   = i_device - DEV_W'(1);
    assign dev_ok   = (i_device != '0) && (dev_ext <= (DEV_W+1)'(NUM_DEVICES));

    assign o_sts.hit      = hit;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;

    always_comb begin
        n_map         = r_map;
        n_act_ptr     = r_act_ptr;
        n_act_vld     = r_act_vld;
        n_ina_ptr     = r_ina_ptr;
        n_ina_vld     = r_ina_vld;
        n_cnt         = r_cnt;
        n_skip        = r_skip;
        n_out_valid   = r_out_valid & ~i_out_ready;
        n_next_device = r_next_device;

        if (i_cmd.take_report && dev_ok) begin
            n_map[dev_m1[IDX_W-1:0]] = i_responded;
        end

        if (i_cmd.take_poll) begin
            n_skip = (r_cnt >= r_period);
            n_cnt  = (r_cnt >= r_period) ? '0 : r_cnt + PERIOD_W'(1);
        end

        if (i_cmd.scan && i_cmd.commit) begin
            if (want_act) begin
                n_act_ptr = hit ? found : r_act_ptr;
                n_act_vld = hit;
            end else begin
                n_ina_ptr = hit ? found : r_ina_ptr;
                n_ina_vld = hit;
            end
            if (hit) begin
                n_out_valid   = 1'b1;
                n_next_device = DEV_W'({1'b0, found} + (IDX_W+1)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_act_ptr   <= IDX_W'(RST_PTR);
            r_act_vld   <= 1'b1;
            r_ina_ptr   <= IDX_W'(RST_PTR);
            r_ina_vld   <= 1'b1;
            r_cnt       <= '0;
            r_skip      <= 1'b0;
            r_period    <= PERIOD_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_map       <= n_map;
            r_act_ptr   <= n_act_ptr;
            r_act_vld   <= n_act_vld;
            r_ina_ptr   <= n_ina_ptr;
            r_ina_vld   <= n_ina_vld;
            r_cnt       <= n_cnt;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_device <= n_next_device;
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_device = r_next_device;

endmodule

`default_nettype wire

// ===== hw/rtl/aips_ctrl.sv =====
// Controller of the poll scheduler: input handshake and search sequencing.
// Depends on aips_pkg.
`default_nettype none

module aips_ctrl import aips_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_mode,
    input  wire t_ctl_sts i_sts,
    output logic          o_in_ready,
    output t_ctl_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0] r_state, n_state;
    logic       accept;
    logic       commit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    // a miss always commits; a hit waits for room in the result register
    assign commit     = ~i_sts.hit | i_sts.out_free;

    always_comb begin
        o_cmd.take_report = accept & (i_mode == MODE_REPORT);
        o_cmd.take_poll   = accept & (i_mode == MODE_POLL);
        o_cmd.scan        = (r_state == ST_FIRST) | (r_state == ST_SECOND);
        o_cmd.second      = (r_state == ST_SECOND);
        o_cmd.commit      = commit;
        n_state           = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_POLL)) begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                if (!i_sts.hit) begin
                    n_state = ST_SECOND;
                end else if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SECOND: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/active_inactive_poll_scheduler.sv =====
// Top level of the active/inactive poll scheduler; joins aips_ctrl and
// aips_datapath, depends on aips_pkg.
// A report word is applied to the map when it is accepted. A poll word runs a
// search pass of the shared rotating search unit over one set, and on a miss
// a fall-through pass over the other set; a hit waits for room in the result
// register. A new word is accepted only once the controller is idle again.
// Reset (sync, active low): map cleared, both pointers at 31 mod N valid,
// counter zero, period 16, no result pending.
`default_nettype none

module active_inactive_poll_scheduler import aips_pkg::*; #(
    parameter int NUM_DEVICES = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration: inactive poll period
    input  wire logic                i_cfg_wr_en,
    input  wire logic [PERIOD_W-1:0] i_cfg_wr_data,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_mode,
    input  wire logic [DEV_W-1:0]    i_device,
    input  wire logic                i_responded,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [DEV_W-1:0]         o_next_device
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Controller: accept a word only when idle; a poll runs the first
    // search, and on a miss the fall-through search. A hit holds until the
    // result register has room; while it holds, no new word is accepted.
    // A report word is still accepted while a finished result waits.
    aips_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath: presence map, pointers, counter, search and result register.
    aips_datapath #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_device      (i_device),
        .i_responded   (i_responded),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_next_device (o_next_device)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/aips_checker.sv =====
// Port-level checker for the poll scheduler, bound to the top level.
// Depends on aips_pkg.
`default_nettype none

module aips_checker import aips_pkg::*; #(
    parameter int NUM_DEVICES = 32
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             i_mode,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [DEV_W-1:0] o_next_device
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_device))
        else $error("result word changed while stalled");

    // device numbers start at 1
    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (NUM_DEVICES == 64) ||
            (o_next_device != '0 && o_next_device <= DEV_W'(NUM_DEVICES)))
        else $error("next device out of range");

    // a report word never produces a result
    a_report_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode == MODE_REPORT && !o_out_valid
            |=> !o_out_valid)
        else $error("result after report word");

    // after a poll word is accepted, ready drops while the search runs
    a_poll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode == MODE_POLL |=> !o_in_ready)
        else $error("ready while poll search in progress");

endmodule

bind active_inactive_poll_scheduler aips_checker #(
    .NUM_DEVICES (NUM_DEVICES)
) u_aips_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_mode        (i_mode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_next_device (o_next_device)
);

`default_nettype wire
